/* design/rect_region_engine_macros.svh */
// Assertion macros shared by the rectangle region engine RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef RECT_REGION_ENGINE_MACROS_SVH
`define RECT_REGION_ENGINE_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define RRE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define RRE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/rre_pkg.sv */
// Package for the rectangle region engine: default sizes, op codes,
// sequencer states and the cover-test result type. No dependencies.
package rre_pkg;

    localparam int RRE_MAX_RECTS  = 256;
    localparam int RRE_COORD_BITS = 16;
    localparam int RRE_IDX_BITS   = 8;
    localparam int RRE_OP_BITS    = 3;

    typedef enum logic [RRE_OP_BITS-1:0] {
        OP_ADD       = 3'd0,
        OP_SUBTRACT  = 3'd1,
        OP_INTERSECT = 3'd2,
        OP_CLEAR     = 3'd3,
        OP_READ      = 3'd4
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD_START,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_CMP_RD,
        S_CMP_CHK,
        S_APPEND,
        S_RB_RD,
        S_RB_LOAD,
        S_RB_ISECT,
        S_PIECE,
        S_READ_RD,
        S_READ_CHK,
        S_RESP
    } t_state;

    typedef struct packed {
        logic ent_covers_cand;
        logic cand_covers_ent;
    } t_cover;

endpackage

/* design/rre_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rre_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* design/rre_cmp.sv */
// Shared containment unit: tests a stored entry against the candidate
// rectangle in both directions. Depends on rre_pkg.
module rre_cmp import rre_pkg::*; #(
    parameter int COORD_BITS = RRE_COORD_BITS
) (
    input  logic signed [COORD_BITS-1:0] i_ex,
    input  logic signed [COORD_BITS-1:0] i_ey,
    input  logic signed [COORD_BITS-1:0] i_ew,
    input  logic signed [COORD_BITS-1:0] i_eh,
    input  logic signed [COORD_BITS-1:0] i_cx,
    input  logic signed [COORD_BITS-1:0] i_cy,
    input  logic signed [COORD_BITS-1:0] i_cw,
    input  logic signed [COORD_BITS-1:0] i_ch,
    output t_cover                       o_cover
);

    logic signed [COORD_BITS:0] er, eb, cr, cb;

    always_comb begin
        er = (COORD_BITS+1)'(i_ex) + (COORD_BITS+1)'(i_ew);
        eb = (COORD_BITS+1)'(i_ey) + (COORD_BITS+1)'(i_eh);
        cr = (COORD_BITS+1)'(i_cx) + (COORD_BITS+1)'(i_cw);
        cb = (COORD_BITS+1)'(i_cy) + (COORD_BITS+1)'(i_ch);
        o_cover.ent_covers_cand = (i_ex <= i_cx) && (i_ey <= i_cy) && (er >= cr) && (eb >= cb);
        o_cover.cand_covers_ent = (i_cx <= i_ex) && (i_cy <= i_ey) && (cr >= er) && (cb >= eb);
    end

endmodule

/* design/rect_region_engine.sv */
// Rectangle region engine top level: sequencer, ping-pong rectangle store
// and piece generation. Depends on rre_pkg, rre_ram, rre_cmp and the macros.
//
// Usage: one op per input transaction (i_in_valid / o_in_ready), one result
// per op on the output channel (o_out_valid / i_out_ready). The block holds
// o_in_ready low from acceptance until the result is loaded into the output
// register; a waiting result does not block the next input transaction.
// An add makes one containment scan and one compaction pass over the list,
// reading each entry through the single RAM read port. Subtract and
// intersect read every entry of the active half and re-add up to four
// pieces per entry into the other half, each through the add sequence;
// the shared RAM port and the shared containment unit serialise this work.
// Reset empties the region and selects half zero; store contents need no
// clearing pass. A stalled receiver only delays the hand-off of the
// finished result into the output register.
`include "rect_region_engine_macros.svh"

module rect_region_engine import rre_pkg::*; #(
    parameter int MAX_RECTS  = RRE_MAX_RECTS,
    parameter int COORD_BITS = RRE_COORD_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [RRE_OP_BITS-1:0]             i_op,
    input  logic signed [COORD_BITS-1:0]       i_rect_left,
    input  logic signed [COORD_BITS-1:0]       i_rect_top,
    input  logic signed [COORD_BITS-1:0]       i_rect_width,
    input  logic signed [COORD_BITS-1:0]       i_rect_height,
    input  logic [RRE_IDX_BITS-1:0]            i_read_index,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [COORD_BITS-1:0]       o_entry_left,
    output logic signed [COORD_BITS-1:0]       o_entry_top,
    output logic [COORD_BITS-2:0]              o_entry_width,
    output logic [COORD_BITS-2:0]              o_entry_height,
    output logic                               o_entry_valid,
    output logic [$clog2(MAX_RECTS+1)-1:0]     o_rect_total,
    output logic                               o_overflow
);

    localparam int CB     = COORD_BITS;
    localparam int CNT_W  = $clog2(MAX_RECTS + 1);
    localparam int DEPTH  = 2 * MAX_RECTS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int WORD_W = 4 * CB;
    localparam logic signed [CB:0] CMAX = {2'b00, {(CB-1){1'b1}}};

    function automatic logic [ADDR_W-1:0] slot(input logic h, input logic [CNT_W-1:0] n);
        slot = h ? ADDR_W'(MAX_RECTS) + ADDR_W'(n) : ADDR_W'(n);
    endfunction

    // control state
    t_state r_state, n_state;
    logic   r_half, n_half;
    logic [CNT_W-1:0] r_count, n_count;
    logic   r_out_valid, n_out_valid;

    // payload state
    t_op r_op, n_op;
    logic signed [CB-1:0] r_sx, n_sx, r_sy, n_sy, r_sw, n_sw, r_sh, n_sh;
    logic [RRE_IDX_BITS-1:0] r_idx, n_idx;
    logic [CNT_W-1:0] r_acnt, n_acnt, r_i, n_i, r_k, n_k, r_j, n_j;
    logic signed [CB-1:0] r_cx, n_cx, r_cy, n_cy, r_cw, n_cw, r_ch, n_ch;
    logic signed [CB-1:0] r_ex, n_ex, r_ey, n_ey, r_ew, n_ew, r_eh, n_eh;
    logic signed [CB-1:0] r_ix, n_ix, r_iy, n_iy;
    logic signed [CB:0]   r_ir, n_ir, r_ib, n_ib;
    logic [2:0] r_pc, n_pc;
    logic r_rebuild, n_rebuild;
    logic r_ovf, n_ovf;
    logic signed [CB-1:0] r_rx, n_rx, r_ry, n_ry, r_rw, n_rw, r_rh, n_rh;
    logic r_rv, n_rv;
    logic signed [CB-1:0] r_ol, n_ol, r_ot, n_ot;
    logic [CB-2:0] r_ow, n_ow, r_oh, n_oh;
    logic r_oev, n_oev;
    logic [CNT_W-1:0] r_otot, n_otot;
    logic r_oovf, n_oovf;

    // RAM port
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [WORD_W-1:0] ram_wdata, ram_rdata;

    logic signed [CB-1:0] rd_x, rd_y, rd_w, rd_h;
    t_cover cmp_res;

    // shared combinational terms
    logic in_acc, dst_half, add_empty, rd_ok, resp_go;
    logic signed [CB:0]   er, eb, sr, sb;
    logic signed [CB+1:0] iw, ih;
    logic overlap, p_take, p_last;
    logic signed [CB:0]   p_x, p_y;
    logic signed [CB+1:0] p_w, p_h;

    rre_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_x = ram_rdata[4*CB-1 -: CB];
    assign rd_y = ram_rdata[3*CB-1 -: CB];
    assign rd_w = ram_rdata[2*CB-1 -: CB];
    assign rd_h = ram_rdata[CB-1 -: CB];

    rre_cmp #(.COORD_BITS(CB)) u_cmp (
        .i_ex (rd_x), .i_ey (rd_y), .i_ew (rd_w), .i_eh (rd_h),
        .i_cx (r_cx), .i_cy (r_cy), .i_cw (r_cw), .i_ch (r_ch),
        .o_cover (cmp_res)
    );

    always_comb begin
        in_acc    = i_in_valid && (r_state == S_IDLE);
        dst_half  = r_rebuild ? ~r_half : r_half;
        add_empty = (r_cw <= 0) || (r_ch <= 0);
        rd_ok     = (32'(i_read_index) < 32'(r_count)) && (32'(i_read_index) < MAX_RECTS);
        resp_go   = !r_out_valid || i_out_ready;

        er = (CB+1)'(r_ex) + (CB+1)'(r_ew);
        eb = (CB+1)'(r_ey) + (CB+1)'(r_eh);
        sr = (CB+1)'(r_sx) + (CB+1)'(r_sw);
        sb = (CB+1)'(r_sy) + (CB+1)'(r_sh);
        iw = (CB+2)'(r_ir) - (CB+2)'(r_ix);
        ih = (CB+2)'(r_ib) - (CB+2)'(r_iy);
        overlap = (iw > 0) && (ih > 0);

        // piece selection for the current source entry
        p_take = 1'b0;
        p_last = 1'b1;
        p_x = (CB+1)'(r_ex);
        p_y = (CB+1)'(r_ey);
        p_w = (CB+2)'(r_ew);
        p_h = (CB+2)'(r_eh);
        if (r_op == OP_INTERSECT) begin
            p_take = overlap && (r_pc == 3'd0);
            p_x = (CB+1)'(r_ix);
            p_y = (CB+1)'(r_iy);
            p_w = iw;
            p_h = ih;
        end else if (!overlap) begin
            p_take = (r_pc == 3'd0);
        end else begin
            p_last = (r_pc >= 3'd3);
            case (r_pc)
                3'd0: begin
                    p_take = r_ey < r_iy;
                    p_h = (CB+2)'(r_iy) - (CB+2)'(r_ey);
                end
                3'd1: begin
                    p_take = (eb > r_ib) && (r_ib <= CMAX);
                    p_y = r_ib;
                    p_h = (CB+2)'(eb) - (CB+2)'(r_ib);
                end
                3'd2: begin
                    p_take = r_ex < r_ix;
                    p_y = (CB+1)'(r_iy);
                    p_w = (CB+2)'(r_ix) - (CB+2)'(r_ex);
                    p_h = ih;
                end
                3'd3: begin
                    p_take = (er > r_ir) && (r_ir <= CMAX);
                    p_x = r_ir;
                    p_y = (CB+1)'(r_iy);
                    p_w = (CB+2)'(er) - (CB+2)'(r_ir);
                    p_h = ih;
                end
                default: begin
                    p_take = 1'b0;
                end
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (t_op'(i_op))
                        OP_ADD:       n_state = S_ADD_START;
                        OP_SUBTRACT:  n_state = ((i_rect_width > 0) && (i_rect_height > 0))
                                                ? S_RB_RD : S_RESP;
                        OP_INTERSECT: n_state = S_RB_RD;
                        OP_READ:      n_state = rd_ok ? S_READ_RD : S_RESP;
                        default:      n_state = S_RESP;
                    endcase
                end
            end
            S_ADD_START: begin
                if (add_empty) begin
                    n_state = r_rebuild ? S_PIECE : S_RESP;
                end else begin
                    n_state = S_SCAN_RD;
                end
            end
            S_SCAN_RD:  n_state = (r_i < r_acnt) ? S_SCAN_CHK : S_CMP_RD;
            S_SCAN_CHK: begin
                if (cmp_res.ent_covers_cand) begin
                    n_state = r_rebuild ? S_PIECE : S_RESP;
                end else begin
                    n_state = S_SCAN_RD;
                end
            end
            S_CMP_RD:   n_state = (r_i < r_acnt) ? S_CMP_CHK : S_APPEND;
            S_CMP_CHK:  n_state = S_CMP_RD;
            S_APPEND:   n_state = r_rebuild ? S_PIECE : S_RESP;
            S_RB_RD:    n_state = (r_j < r_count) ? S_RB_LOAD : S_RESP;
            S_RB_LOAD:  n_state = S_RB_ISECT;
            S_RB_ISECT: n_state = S_PIECE;
            S_PIECE: begin
                if (p_take) begin
                    n_state = S_ADD_START;
                end else if (p_last) begin
                    n_state = S_RB_RD;
                end
            end
            S_READ_RD:  n_state = S_READ_CHK;
            S_READ_CHK: n_state = S_RESP;
            S_RESP:     n_state = resp_go ? S_IDLE : S_RESP;
            default:    n_state = S_IDLE;
        endcase
    end

    // datapath and RAM controls
    always_comb begin
        n_half = r_half;     n_count = r_count;   n_op = r_op;
        n_sx = r_sx; n_sy = r_sy; n_sw = r_sw; n_sh = r_sh; n_idx = r_idx;
        n_acnt = r_acnt; n_i = r_i; n_k = r_k; n_j = r_j;
        n_cx = r_cx; n_cy = r_cy; n_cw = r_cw; n_ch = r_ch;
        n_ex = r_ex; n_ey = r_ey; n_ew = r_ew; n_eh = r_eh;
        n_ix = r_ix; n_iy = r_iy; n_ir = r_ir; n_ib = r_ib;
        n_pc = r_pc; n_rebuild = r_rebuild; n_ovf = r_ovf;
        n_rx = r_rx; n_ry = r_ry; n_rw = r_rw; n_rh = r_rh; n_rv = r_rv;
        n_ol = r_ol; n_ot = r_ot; n_ow = r_ow; n_oh = r_oh; n_oev = r_oev;
        n_otot = r_otot; n_oovf = r_oovf;
        n_out_valid = r_out_valid && !i_out_ready;
        ram_we    = 1'b0;
        ram_waddr = slot(dst_half, r_k);
        ram_wdata = ram_rdata;
        ram_raddr = slot(dst_half, r_i);

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_op = t_op'(i_op);
                    n_sx = i_rect_left;  n_sy = i_rect_top;
                    n_sw = i_rect_width; n_sh = i_rect_height;
                    n_idx = i_read_index;
                    n_cx = i_rect_left;  n_cy = i_rect_top;
                    n_cw = i_rect_width; n_ch = i_rect_height;
                    n_ovf = 1'b0;
                    n_rv = 1'b0;
                    n_rebuild = (t_op'(i_op) != OP_ADD);
                    n_acnt = (t_op'(i_op) == OP_ADD) ? r_count : '0;
                    n_j = '0;
                    if (t_op'(i_op) == OP_CLEAR) begin
                        n_count = '0;
                    end
                end
            end
            S_ADD_START: begin
                n_i = '0;
                if (add_empty && !r_rebuild) begin
                    n_count = r_acnt;
                end
            end
            S_SCAN_RD: begin
                if (r_i < r_acnt) begin
                    ram_raddr = slot(dst_half, r_i);
                end else begin
                    n_i = '0;
                    n_k = '0;
                end
            end
            S_SCAN_CHK: begin
                n_i = r_i + 1'b1;
                if (cmp_res.ent_covers_cand && !r_rebuild) begin
                    n_count = r_acnt;
                end
            end
            S_CMP_RD: begin
                if (!(r_i < r_acnt)) begin
                    n_acnt = r_k;
                end
            end
            S_CMP_CHK: begin
                // keep entries the candidate does not cover, in order
                if (!cmp_res.cand_covers_ent) begin
                    ram_we    = 1'b1;
                    ram_waddr = slot(dst_half, r_k);
                    ram_wdata = ram_rdata;
                    n_k = r_k + 1'b1;
                end
                n_i = r_i + 1'b1;
            end
            S_APPEND: begin
                if (r_acnt == CNT_W'(MAX_RECTS)) begin
                    n_ovf = 1'b1;
                    if (!r_rebuild) begin
                        n_count = r_acnt;
                    end
                end else begin
                    ram_we    = 1'b1;
                    ram_waddr = slot(dst_half, r_acnt);
                    ram_wdata = {r_cx, r_cy, r_cw, r_ch};
                    n_acnt = r_acnt + 1'b1;
                    if (!r_rebuild) begin
                        n_count = r_acnt + 1'b1;
                    end
                end
            end
            S_RB_RD: begin
                ram_raddr = slot(r_half, r_j);
                if (!(r_j < r_count)) begin
                    n_count = r_acnt;
                    n_half  = ~r_half;
                end
            end
            S_RB_LOAD: begin
                n_ex = rd_x; n_ey = rd_y; n_ew = rd_w; n_eh = rd_h;
                n_j = r_j + 1'b1;
            end
            S_RB_ISECT: begin
                n_ix = (r_ex > r_sx) ? r_ex : r_sx;
                n_iy = (r_ey > r_sy) ? r_ey : r_sy;
                n_ir = (er < sr) ? er : sr;
                n_ib = (eb < sb) ? eb : sb;
                n_pc = '0;
            end
            S_PIECE: begin
                n_pc = r_pc + 1'b1;
                if (p_take) begin
                    n_cx = p_x[CB-1:0];
                    n_cy = p_y[CB-1:0];
                    n_cw = p_w[CB-1:0];
                    n_ch = p_h[CB-1:0];
                end
            end
            S_READ_RD: begin
                ram_raddr = slot(r_half, CNT_W'(r_idx));
            end
            S_READ_CHK: begin
                n_rx = rd_x; n_ry = rd_y; n_rw = rd_w; n_rh = rd_h;
                n_rv = 1'b1;
            end
            S_RESP: begin
                if (resp_go) begin
                    n_out_valid = 1'b1;
                    n_ol   = r_rv ? r_rx : '0;
                    n_ot   = r_rv ? r_ry : '0;
                    n_ow   = r_rv ? r_rw[CB-2:0] : '0;
                    n_oh   = r_rv ? r_rh[CB-2:0] : '0;
                    n_oev  = r_rv;
                    n_otot = r_count;
                    n_oovf = r_ovf;
                end
            end
            default: begin
                n_out_valid = r_out_valid && !i_out_ready;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_half      <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_half      <= n_half;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op <= n_op;
        r_sx <= n_sx; r_sy <= n_sy; r_sw <= n_sw; r_sh <= n_sh; r_idx <= n_idx;
        r_acnt <= n_acnt; r_i <= n_i; r_k <= n_k; r_j <= n_j;
        r_cx <= n_cx; r_cy <= n_cy; r_cw <= n_cw; r_ch <= n_ch;
        r_ex <= n_ex; r_ey <= n_ey; r_ew <= n_ew; r_eh <= n_eh;
        r_ix <= n_ix; r_iy <= n_iy; r_ir <= n_ir; r_ib <= n_ib;
        r_pc <= n_pc; r_rebuild <= n_rebuild; r_ovf <= n_ovf;
        r_rx <= n_rx; r_ry <= n_ry; r_rw <= n_rw; r_rh <= n_rh; r_rv <= n_rv;
        r_ol <= n_ol; r_ot <= n_ot; r_ow <= n_ow; r_oh <= n_oh; r_oev <= n_oev;
        r_otot <= n_otot; r_oovf <= n_oovf;
    end

    assign o_in_ready     = (r_state == S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_entry_left   = r_ol;
    assign o_entry_top    = r_ot;
    assign o_entry_width  = r_ow;
    assign o_entry_height = r_oh;
    assign o_entry_valid  = r_oev;
    assign o_rect_total   = r_otot;
    assign o_overflow     = r_oovf;

    `RRE_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(MAX_RECTS), "rect count above capacity")
    `RRE_ASSERT_NOW(a_compact_order, i_clk, i_rst_n, r_state == S_CMP_CHK, r_k <= r_i, "compaction write ahead of read")
    `RRE_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && o_in_ready, r_state != S_IDLE, "sequencer idle after accept")
    `RRE_ASSERT_NEXT(a_resp_loads, i_clk, i_rst_n, (r_state == S_RESP) && (!r_out_valid || i_out_ready), r_out_valid && (r_state == S_IDLE), "result not loaded")

endmodule
